[rtl/qm_arithmetic_decoder_macros.svh]
`ifndef QM_ARITHMETIC_DECODER_MACROS_SVH
`define QM_ARITHMETIC_DECODER_MACROS_SVH

// same-cycle implication
`define QMAD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QMAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/qmad_pkg.sv]
package qmad_pkg;

   localparam int BUF_DEPTH_DEF = 4096;
   localparam int CONTEXTS_DEF  = 65536;
   localparam int QE_ENTRIES    = 47;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_DECODE = 2'd2;

   localparam logic [15:0] INIT_INTERVAL = 16'h8000;
   localparam logic [7:0]  BYTE_FF       = 8'hFF;
   localparam logic [7:0]  MARKER_LIMIT  = 8'h8F;
   localparam logic [31:0] BYTE_ADD      = 32'h0000_FF00;
   localparam logic [31:0] STUFF_ADD     = 32'h0000_FE00;
   localparam logic [5:0]  IDX_LAST      = 6'd46;

   localparam logic [15:0] QE_PROB [QE_ENTRIES] = '{
      16'h5601, 16'h3401, 16'h1801, 16'h0AC1, 16'h0521, 16'h0221, 16'h5601, 16'h5401,
      16'h4801, 16'h3801, 16'h3001, 16'h2401, 16'h1C01, 16'h1601, 16'h5601, 16'h5401,
      16'h5101, 16'h4801, 16'h3801, 16'h3401, 16'h3001, 16'h2801, 16'h2401, 16'h2201,
      16'h1C01, 16'h1801, 16'h1601, 16'h1401, 16'h1201, 16'h1101, 16'h0AC1, 16'h09C1,
      16'h08A1, 16'h0521, 16'h0441, 16'h02A1, 16'h0221, 16'h0141, 16'h0111, 16'h0085,
      16'h0049, 16'h0025, 16'h0015, 16'h0009, 16'h0005, 16'h0001, 16'h5601};

   localparam logic [5:0] NEXT_MPS [QE_ENTRIES] = '{
      6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd38, 6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12,
      6'd13, 6'd29, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
      6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36,
      6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd45, 6'd46};

   localparam logic [5:0] NEXT_LPS [QE_ENTRIES] = '{
      6'd1,  6'd6,  6'd9,  6'd12, 6'd29, 6'd33, 6'd6,  6'd14, 6'd14, 6'd14, 6'd17, 6'd18,
      6'd20, 6'd21, 6'd14, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20, 6'd21,
      6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33,
      6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd46};

   localparam logic FLIP_MPS [QE_ENTRIES] = '{
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

endpackage

[rtl/qm_arithmetic_decoder.sv]
// QM-coder adaptive binary arithmetic decoder.
// Input channel req_*: one transaction per item. req_kind selects a byte load
// (req_data_byte, req_new_stream empties the buffer first), a start of decoding,
// or a decode of one decision under context req_context_id; kind 3 is ignored.
// Result channel rsp_*: one transaction per decode, carrying the decision and
// whether the read pointer has reached the end of the loaded data.
// A load or an unused kind is handled in the idle state; a start runs ST0, ST1,
// the byte fetch BI0 to BI2 and ST2. A decode runs CTX, DEC0 and DEC1, then,
// unless the interval is still normalized, one renormalizing shift per cycle
// (up to 16) in RN, pausing for a byte fetch from the buffer when the bit
// count runs out, and FIN to hand the result over; a context count that is
// not a power of two first reduces the id in RED. One item is in work at a time.
// After reset the context table is cleared one entry a cycle, all CONTEXTS
// entries, with req_ready low. The coder registers and buffer length clear at
// once. When the receiver stalls the result holds in the output register;
// loads and starts are still taken, but a further decode waits in FIN for it.
module qm_arithmetic_decoder #(
   parameter int BUF_DEPTH = qmad_pkg::BUF_DEPTH_DEF,
   parameter int CONTEXTS  = qmad_pkg::CONTEXTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic        req_new_stream,
   input  logic [15:0] req_context_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_decision,
   output logic        rsp_past_end
);
   import qmad_pkg::*;

   localparam int PW  = $clog2(BUF_DEPTH + 1);
   localparam int AW  = $clog2(BUF_DEPTH);
   localparam int CXW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
   localparam bit CX_POW2 = ((CONTEXTS & (CONTEXTS - 1)) == 0);
   localparam logic [4:0]     RED_TOP = 5'(16 - $clog2(CONTEXTS));
   localparam logic [PW-1:0]  DEPTH_P = PW'(BUF_DEPTH);
   localparam logic [CXW-1:0] CX_LAST = CXW'(CONTEXTS - 1);
   localparam logic [16:0]    CX_MASK = 17'(CONTEXTS - 1);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_RED, S_CTX, S_DEC0, S_DEC1, S_RN,
      S_ST0, S_ST1, S_ST2, S_BI0, S_BI1, S_BI2, S_FIN
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [31:0]    code_ff, code_in;
   logic [15:0]    interval_ff, interval_in;
   logic [3:0]     ct_ff, ct_in;
   logic [PW-1:0]  rp_ff, rp_in;
   logic [PW-1:0]  dl_ff, dl_in;
   logic [CXW-1:0] clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_dec_ff, rsp_dec_in;
   logic           rsp_pe_ff, rsp_pe_in;

   logic [15:0] red_ff, red_in;
   logic [4:0]  kstep_ff, kstep_in;
   logic [15:0] qe_ff, qe_in;
   logic [5:0]  idx_ff, idx_in;
   logic        mps_ff, mps_in;
   logic        dec_ff, dec_in;
   logic [3:0]  n_ff, n_in;
   logic [7:0]  buf_rd_ff;
   logic        inr_ff, inr_in;
   logic        ff0_ff, ff0_in;
   logic [6:0]  ctx_rd_ff;

   logic [7:0]     buf_mem [BUF_DEPTH];
   logic [6:0]     ctx_mem [CONTEXTS];
   logic           buf_we;
   logic [AW-1:0]  buf_waddr;
   logic [AW-1:0]  buf_raddr;
   logic [PW:0]    buf_pos;
   logic           ctx_we;
   logic [CXW-1:0] ctx_waddr;
   logic [6:0]     ctx_wdata;
   logic [CXW-1:0] cx;

   logic [PW-1:0]  dl_eff;
   logic [32:0]    red_cmp;
   logic [7:0]     byte_now;
   logic [5:0]     idx_clamp;
   logic [15:0]    qe_now;
   logic           lower;
   logic           less;
   logic           take_lps;
   logic [15:0]    interval_shl;

   assign cx        = red_ff[CXW-1:0];
   assign buf_raddr = buf_pos[AW-1:0];
   assign byte_now  = inr_ff ? buf_rd_ff : BYTE_FF;
   assign red_cmp   = 33'(CONTEXTS) << kstep_ff;
   assign idx_clamp = (ctx_rd_ff[5:0] > IDX_LAST) ? IDX_LAST : ctx_rd_ff[5:0];
   assign qe_now    = QE_PROB[idx_clamp];
   assign lower     = code_ff < {interval_ff, 16'h0000};
   assign less      = interval_ff < qe_ff;
   assign take_lps  = lower ? less : !less;
   assign interval_shl = {interval_ff[14:0], 1'b0};
   assign dl_eff    = req_new_stream ? '0 : dl_ff;
   assign inr_in    = (buf_pos < {1'b0, dl_ff}) && (buf_pos < {1'b0, DEPTH_P});

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_decision = rsp_dec_ff;
   assign rsp_past_end = rsp_pe_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      code_in      = code_ff;
      interval_in  = interval_ff;
      ct_in        = ct_ff;
      rp_in        = rp_ff;
      dl_in        = dl_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dec_in   = rsp_dec_ff;
      rsp_pe_in    = rsp_pe_ff;
      red_in       = red_ff;
      kstep_in     = kstep_ff;
      qe_in        = qe_ff;
      idx_in       = idx_ff;
      mps_in       = mps_ff;
      dec_in       = dec_ff;
      n_in         = n_ff;
      ff0_in       = ff0_ff;
      buf_pos      = {1'b0, rp_ff};
      buf_we       = 1'b0;
      buf_waddr    = dl_eff[AW-1:0];
      ctx_we       = 1'b0;
      ctx_waddr    = cx;
      ctx_wdata    = '0;
      unique case (state_ff)
         S_CLR: begin
            ctx_we    = 1'b1;
            ctx_waddr = clr_ff;
            clr_in    = clr_ff + CXW'(1);
            if (clr_ff == CX_LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_LOAD: begin
                     if (dl_eff < DEPTH_P) begin
                        buf_we = 1'b1;
                        dl_in  = dl_eff + PW'(1);
                     end else begin
                        dl_in  = dl_eff;
                     end
                  end
                  KIND_START: begin
                     rp_in    = '0;
                     state_in = S_ST0;
                  end
                  KIND_DECODE: begin
                     kstep_in = RED_TOP;
                     if (CX_POW2) begin
                        red_in   = req_context_id & CX_MASK[15:0];
                        state_in = S_CTX;
                     end else begin
                        red_in   = req_context_id;
                        state_in = S_RED;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RED: begin
            if ({17'h00000, red_ff} >= red_cmp) red_in = red_ff - red_cmp[15:0];
            kstep_in = kstep_ff - 5'd1;
            if (kstep_ff == 5'd0) state_in = S_CTX;
         end
         S_CTX: state_in = S_DEC0;
         S_DEC0: begin
            qe_in       = qe_now;
            idx_in      = idx_clamp;
            mps_in      = ctx_rd_ff[6];
            interval_in = interval_ff - qe_now;
            state_in    = S_DEC1;
         end
         S_DEC1: begin
            if (lower && interval_ff[15]) begin
               dec_in   = mps_ff;
               state_in = S_FIN;
            end else begin
               if (take_lps) begin
                  dec_in    = !mps_ff;
                  ctx_wdata = {mps_ff ^ FLIP_MPS[idx_ff], NEXT_LPS[idx_ff]};
               end else begin
                  dec_in    = mps_ff;
                  ctx_wdata = {mps_ff, NEXT_MPS[idx_ff]};
               end
               if (!lower) begin
                  code_in     = code_ff - {interval_ff, 16'h0000};
                  interval_in = qe_ff;
               end
               ctx_we   = 1'b1;
               n_in     = '0;
               state_in = S_RN;
            end
         end
         S_RN: begin
            if (ct_ff == 4'd0) begin
               ret_in   = S_RN;
               state_in = S_BI0;
            end else begin
               interval_in = interval_shl;
               code_in     = {code_ff[30:0], 1'b0};
               ct_in       = ct_ff - 4'd1;
               n_in        = n_ff + 4'd1;
               if (interval_shl[15] || n_ff == 4'd15) state_in = S_FIN;
            end
         end
         S_ST0: state_in = S_ST1;
         S_ST1: begin
            code_in  = {8'h00, byte_now ^ BYTE_FF, 16'h0000};
            ret_in   = S_ST2;
            state_in = S_BI0;
         end
         S_ST2: begin
            code_in     = {code_ff[24:0], 7'b0000000};
            ct_in       = ct_ff - 4'd7;
            interval_in = INIT_INTERVAL;
            state_in    = S_IDLE;
         end
         S_BI0: state_in = S_BI1;
         S_BI1: begin
            buf_pos  = {1'b0, rp_ff} + (PW + 1)'(1);
            ff0_in   = (byte_now == BYTE_FF);
            state_in = S_BI2;
         end
         S_BI2: begin
            if (!ff0_ff) begin
               rp_in   = rp_ff + PW'(1);
               code_in = code_ff + BYTE_ADD - {16'h0000, byte_now, 8'h00};
               ct_in   = 4'd8;
            end else if (byte_now > MARKER_LIMIT) begin
               ct_in = 4'd8;
            end else begin
               rp_in   = rp_ff + PW'(1);
               code_in = code_ff + STUFF_ADD - {15'h0000, byte_now, 9'h000};
               ct_in   = 4'd7;
            end
            state_in = ret_ff;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_dec_in   = dec_ff;
               rsp_pe_in    = rp_ff >= dl_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         ret_ff       <= S_IDLE;
         code_ff      <= '0;
         interval_ff  <= '0;
         ct_ff        <= '0;
         rp_ff        <= '0;
         dl_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         code_ff      <= code_in;
         interval_ff  <= interval_in;
         ct_ff        <= ct_in;
         rp_ff        <= rp_in;
         dl_ff        <= dl_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_dec_ff <= rsp_dec_in;
      rsp_pe_ff  <= rsp_pe_in;
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      kstep_ff <= kstep_in;
      qe_ff    <= qe_in;
      idx_ff   <= idx_in;
      mps_ff   <= mps_in;
      dec_ff   <= dec_in;
      n_ff     <= n_in;
      inr_ff   <= inr_in;
      ff0_ff   <= ff0_in;
   end

   always_ff @(posedge clock) begin
      if (buf_we) buf_mem[buf_waddr] <= req_data_byte;
      buf_rd_ff <= buf_mem[buf_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctx_we) ctx_mem[ctx_waddr] <= ctx_wdata;
      ctx_rd_ff <= ctx_mem[cx];
   end

`include "qm_arithmetic_decoder_macros.svh"

   `QMAD_ASSERT_NOW(a_rn_unnormalised, clock, reset, state_ff == S_RN, !interval_ff[15], "renormalising an already normalised interval")
   `QMAD_ASSERT_NEXT(a_byte_in_count, clock, reset, state_ff == S_BI2, (ct_ff == 4'd7 || ct_ff == 4'd8), "bit count not reloaded after byte fetch")
   `QMAD_ASSERT_NOW(a_rp_bound, clock, reset, 1'b1, rp_ff <= DEPTH_P, "read pointer beyond buffer depth")

endmodule

[tb/sv/tb_qm_arithmetic_decoder.sv]
`timescale 1ns / 1ps

module tb_qm_arithmetic_decoder;
   import qmad_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int BUF_SLOTS = BUF_DEPTH_DEF;
   localparam int BUF_AW = $clog2(BUF_SLOTS);
   localparam int CTX_SLOTS = CONTEXTS_DEF;
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int MAIN_ITEMS = 1550;
   localparam logic [46:0] FLIP_MASK = 47'h0000_0000_4041;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  dbyte;
      logic        restart;
      logic [15:0] ctx;
      logic        typed;
      logic        exp_dec;
      logic        exp_end;
   } stim_row_type;

   typedef struct packed {
      logic decision;
      logic past_end;
   } dec_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = KIND_UNUSED;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_new_stream = 1'b0;
   logic [15:0] req_context_id = 16'h0000;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_decision;
   logic        rsp_past_end;
   logic        hold_rsp = 1'b0;

   // probability estimation tables
   logic [15:0] qe_tab [0:46] = '{
      16'h5601, 16'h3401, 16'h1801, 16'h0AC1, 16'h0521, 16'h0221, 16'h5601, 16'h5401,
      16'h4801, 16'h3801, 16'h3001, 16'h2401, 16'h1C01, 16'h1601, 16'h5601, 16'h5401,
      16'h5101, 16'h4801, 16'h3801, 16'h3401, 16'h3001, 16'h2801, 16'h2401, 16'h2201,
      16'h1C01, 16'h1801, 16'h1601, 16'h1401, 16'h1201, 16'h1101, 16'h0AC1, 16'h09C1,
      16'h08A1, 16'h0521, 16'h0441, 16'h02A1, 16'h0221, 16'h0141, 16'h0111, 16'h0085,
      16'h0049, 16'h0025, 16'h0015, 16'h0009, 16'h0005, 16'h0001, 16'h5601};
   logic [5:0] mps_tab [0:46] = '{
      1, 2, 3, 4, 5, 38, 7, 8, 9, 10, 11, 12, 13, 29, 15, 16,
      17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 32,
      33, 34, 35, 36, 37, 38, 39, 40, 41, 42, 43, 44, 45, 45, 46};
   logic [5:0] lps_tab [0:46] = '{
      1, 6, 9, 12, 29, 33, 6, 14, 14, 14, 17, 18, 20, 21, 14, 14,
      15, 16, 17, 18, 19, 19, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29,
      30, 31, 32, 33, 34, 35, 36, 37, 38, 39, 40, 41, 42, 43, 46};

   logic [31:0] coder_c;
   logic [15:0] coder_a;
   logic [3:0]  coder_ct;
   int unsigned rd_pos;
   int unsigned buf_len;
   logic [7:0]  buf_mem [0:BUF_SLOTS-1];
   logic [6:0]  ctx_mem [0:CTX_SLOTS-1];

   dec_result_type decoded_q [$];
   int mismatches = 0;
   int results_seen = 0;
   int items_sent = 0;
   int send_calm = 0;

   stim_row_type stim_rows [0:23] = '{
      {KIND_DECODE, 8'h00, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1},
      {KIND_DECODE, 8'h00, 1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1},
      {KIND_UNUSED, 8'hFF, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0},
      {KIND_LOAD,   8'h00, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_LOAD,   8'hFF, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_LOAD,   8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_LOAD,   8'hFF, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_LOAD,   8'h8F, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_LOAD,   8'h55, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_LOAD,   8'hFF, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_LOAD,   8'h90, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_START,  8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_DECODE, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_DECODE, 8'h00, 1'b0, 16'h0001, 1'b0, 1'b0, 1'b0},
      {KIND_DECODE, 8'h00, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0},
      {KIND_DECODE, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_DECODE, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_DECODE, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_DECODE, 8'h00, 1'b0, 16'h8000, 1'b0, 1'b0, 1'b0},
      {KIND_DECODE, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_LOAD,   8'hAA, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_DECODE, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_START,  8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
      {KIND_DECODE, 8'h00, 1'b0, 16'h7FFF, 1'b0, 1'b0, 1'b0}};

   qm_arithmetic_decoder #(
      .BUF_DEPTH(BUF_SLOTS),
      .CONTEXTS(CTX_SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_data_byte(req_data_byte),
      .req_new_stream(req_new_stream),
      .req_context_id(req_context_id),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_decision(rsp_decision),
      .rsp_past_end(rsp_past_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] buf_peek(input int unsigned offset);
      int unsigned pos;
      pos = rd_pos + offset;
      if (pos >= buf_len || pos >= BUF_SLOTS) return 8'hFF;
      return buf_mem[pos[BUF_AW-1:0]];
   endfunction

   function automatic void qm_byte_in();
      if (buf_peek(0) == 8'hFF) begin
         if (buf_peek(1) > 8'h8F) begin
            coder_ct = 4'd8;
         end else begin
            rd_pos++;
            coder_c = coder_c + 32'h0000_FE00 - ({24'h0, buf_peek(0)} << 9);
            coder_ct = 4'd7;
         end
      end else begin
         rd_pos++;
         coder_c = coder_c + 32'h0000_FF00 - ({24'h0, buf_peek(0)} << 8);
         coder_ct = 4'd8;
      end
   endfunction

   function automatic void qm_renorm();
      int n;
      n = 0;
      do begin
         if (coder_ct == 4'd0) qm_byte_in();
         coder_a = coder_a << 1;
         coder_c = coder_c << 1;
         coder_ct = coder_ct - 4'd1;
         n++;
      end while (!coder_a[15] && n < 16);
   endfunction

   function automatic void qm_start();
      rd_pos = 0;
      coder_c = {8'h00, buf_peek(0) ^ 8'hFF, 16'h0000};
      qm_byte_in();
      coder_c = coder_c << 7;
      coder_ct = coder_ct - 4'd7;
      coder_a = 16'h8000;
   endfunction

   function automatic logic qm_decode(input logic [15:0] cx);
      logic [6:0]  entry;
      logic [5:0]  idx;
      logic [15:0] qe;
      logic        mps;
      logic        d;
      entry = ctx_mem[cx];
      idx = entry[5:0];
      mps = entry[6];
      if (idx > 6'd46) idx = 6'd46;
      qe = qe_tab[idx];
      coder_a = coder_a - qe;
      if (coder_c < {coder_a, 16'h0000}) begin
         if (coder_a[15]) return mps;
         if (coder_a < qe) begin
            d = ~mps;
            if (FLIP_MASK[idx]) mps = ~mps;
            idx = lps_tab[idx];
         end else begin
            d = mps;
            idx = mps_tab[idx];
         end
      end else begin
         coder_c = coder_c - {coder_a, 16'h0000};
         if (coder_a < qe) begin
            d = mps;
            idx = mps_tab[idx];
         end else begin
            d = ~mps;
            if (FLIP_MASK[idx]) mps = ~mps;
            idx = lps_tab[idx];
         end
         coder_a = qe;
      end
      ctx_mem[cx] = {mps, idx};
      qm_renorm();
      return d;
   endfunction

   function automatic void qm_apply_item(input stim_row_type row, output logic has_rsp,
                                         output dec_result_type res);
      has_rsp = 1'b0;
      res = '0;
      case (row.kind)
         KIND_LOAD: begin
            if (row.restart) buf_len = 0;
            if (buf_len < BUF_SLOTS) begin
               buf_mem[buf_len[BUF_AW-1:0]] = row.dbyte;
               buf_len++;
            end
         end
         KIND_START: begin
            qm_start();
         end
         KIND_DECODE: begin
            res.decision = qm_decode(row.ctx);
            res.past_end = (rd_pos >= buf_len);
            has_rsp = 1'b1;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic stim_row_type make_row(input logic [1:0] kind, input logic [7:0] dbyte,
                                             input logic restart, input logic [15:0] ctx);
      stim_row_type row;
      row = '0;
      row.kind = kind;
      row.dbyte = dbyte;
      row.restart = restart;
      row.ctx = ctx;
      return row;
   endfunction

   function automatic int sender_gap();
      int r;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         send_calm = $urandom_range(30, 120);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] stream_byte(input int style);
      int r;
      r = $urandom_range(0, 99);
      case (style)
         0: begin
            if (r < 12) return 8'hFF;
            if (r < 20) return 8'h00;
            return 8'($urandom_range(0, 255));
         end
         1: begin
            if (r < 85) return 8'($urandom_range(8'hC0, 8'hFE));
            return 8'($urandom_range(0, 255));
         end
         default: begin
            if (r < 40) return 8'hFF;
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int expv, input int gotv);
      $display("ERROR result %0d: %s expected %0d got %0d", results_seen, what, expv, gotv);
      mismatches++;
   endtask

   task automatic send_item(input stim_row_type row);
      dec_result_type predicted;
      logic has_rsp;
      int gap;
      req_valid <= 1'b1;
      req_kind <= row.kind;
      req_data_byte <= row.dbyte;
      req_new_stream <= row.restart;
      req_context_id <= row.ctx;
      do @(posedge clock); while (!req_ready);
      qm_apply_item(row, has_rsp, predicted);
      if (has_rsp) begin
         if (row.typed) begin
            predicted.decision = row.exp_dec;
            predicted.past_end = row.exp_end;
         end
         decoded_q.push_back(predicted);
      end
      items_sent++;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_stream();
      logic [15:0] pool [0:3];
      int n;
      int m;
      int style;
      int r;
      for (int i = 0; i < 4; i++) pool[i[1:0]] = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0) pool[0] = 16'h0000;
      if ($urandom_range(0, 3) == 0) pool[3] = 16'hFFFF;
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 64);
      style = $urandom_range(0, 2);
      for (int i = 0; i < n; i++)
         send_item(make_row(KIND_LOAD, stream_byte(style), i == 0,
                            16'($urandom_range(0, 65535))));
      if ($urandom_range(0, 9) != 0)
         send_item(make_row(KIND_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            16'($urandom_range(0, 65535))));
      m = $urandom_range(1, 6 * n + 6);
      for (int j = 0; j < m; j++) begin
         r = $urandom_range(0, 99);
         if (r < 4)
            send_item(make_row(KIND_LOAD, stream_byte(style), 1'b0,
                               16'($urandom_range(0, 65535))));
         else if (r < 5)
            send_item(make_row(KIND_LOAD, stream_byte(style), 1'b1,
                               16'($urandom_range(0, 65535))));
         send_item(make_row(KIND_DECODE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            pool[2'($urandom_range(0, 3))]));
      end
   endtask

   task automatic run_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n)
         send_item(make_row(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535))));
   endtask

   task automatic check_result();
      dec_result_type want;
      results_seen++;
      if (decoded_q.size() == 0) begin
         report_mismatch("unexpected transaction, decision", -1, int'(rsp_decision));
      end else begin
         want = decoded_q.pop_front();
         if (rsp_decision !== want.decision)
            report_mismatch("decision", int'(want.decision), int'(rsp_decision));
         if (rsp_past_end !== want.past_end)
            report_mismatch("past_end", int'(want.past_end), int'(rsp_past_end));
      end
   endtask

   initial begin : rsp_side
      int stall_left;
      int calm_left;
      int r;
      stall_left = 0;
      calm_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_result();
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
               calm_left = $urandom_range(50, 300);
               rsp_ready <= 1'b1;
            end else if (r < 70) begin
               rsp_ready <= 1'b1;
            end else if (r < 95) begin
               stall_left = $urandom_range(0, 2);
               rsp_ready <= 1'b0;
            end else begin
               stall_left = $urandom_range(10, 40);
               rsp_ready <= 1'b0;
            end
         end
      end
   end

   // long hold on the result side while requests keep coming
   initial begin : rsp_hold
      wait (results_seen >= 150);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (800) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("qm_arithmetic_decoder regression: fail");
      $finish;
   end

   initial begin : req_side
      int base;
      int r;
      coder_c = '0;
      coder_a = '0;
      coder_ct = '0;
      rd_pos = 0;
      buf_len = 0;
      for (int i = 0; i < CTX_SLOTS; i++) ctx_mem[i[15:0]] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (stim_rows[i]) send_item(stim_rows[i]);
      drain_results();
      base = items_sent;
      while (items_sent - base < MAIN_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            run_stream();
         end else if (r < 90) begin
            run_noise();
         end else if (r < 96) begin
            repeat ($urandom_range(1, 6))
               send_item(make_row(KIND_DECODE, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535))));
         end else begin
            drain_results();
         end
      end
      drain_results();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && decoded_q.size() == 0) begin
         $display("qm_arithmetic_decoder regression: pass");
      end else begin
         $display("qm_arithmetic_decoder regression: fail");
      end
      $finish;
   end

endmodule
